### rtl/rtcm3_frame_checker_macros.svh
// Assertion macros for the RTCM 3 frame checker.
`ifndef RTCM3_FRAME_CHECKER_MACROS_SVH
`define RTCM3_FRAME_CHECKER_MACROS_SVH
`ifndef SYNTHESIS
`define RFC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rtcm3 frame checker assertion failed");
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtcm3 frame checker assertion failed");
`else
`define RFC_ASSERT(label, clk, rst_n, prop)
`define RFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rtcm3fc_pkg.sv
// Types, constants and CRC-24Q byte update for the RTCM 3 frame checker.
package rtcm3fc_pkg;

	localparam int unsigned POS_W = 11;
	localparam int unsigned LEN_W = 10;
	localparam int unsigned CRC_W = 24;

	localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;
	localparam logic [POS_W-1:0] HEADER_BYTES = 11'd3;
	localparam logic [POS_W-1:0] OVERHEAD_BYTES = 11'd6;
	localparam logic [7:0] PREAMBLE_RESET = 8'd211;

	typedef enum logic [1:0] {
		VERDICT_OK           = 2'd0,
		VERDICT_BAD_PREAMBLE = 2'd1,
		VERDICT_TOO_SHORT    = 2'd2,
		VERDICT_CRC_MISMATCH = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		verdict_t           verdict;
		logic [POS_W-1:0]   frame_length;
		logic [CRC_W-1:0]   computed_crc;
	} out_item_t;

	// MSB-first CRC-24Q over one byte; eight xor/shift steps on 24 bits.
	function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 16'h0000};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/rtcm3_frame_checker.sv
// RTCM 3 frame checker: preamble, length and CRC-24Q check over a byte stream.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one buffer byte per transfer;
//    in_data.last_byte marks the final byte, the next transfer starts a new buffer.
//  - Output channel (out_valid / out_stall / out_data): one verdict per buffer, on
//    the marked byte only: verdict, frame length (payload + 6) and computed CRC.
//  - Config: cfg_we writes cfg_wdata into the preamble register; write only
//    while no buffer is in flight.
//  - Pipeline: a byte is registered in the input stage, the state and CRC
//    update runs on it and loads the verdict into the output register as the
//    last byte leaves the input stage; out_stall can hold the result there.
//  - Throughput: one byte per cycle while no result is held under out_stall.
//  - Reset: clears both valid flags and all frame state, preamble = 0xD3.
//  - Stall: a result held under out_stall freezes the pipeline; in_stall rises
//    only while the input stage also holds a byte, so an empty stage still
//    takes one more byte.
//  - Buffers longer than MAX_BUFFER_BYTES: extra bytes are dropped; their
//    last-byte mark still closes the buffer.
module rtcm3_frame_checker #(
	parameter int unsigned MAX_BUFFER_BYTES = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rtcm3fc_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rtcm3fc_pkg::out_item_t out_data
);
	import rtcm3fc_pkg::*;

`include "rtcm3_frame_checker_macros.svh"

	localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_BUFFER_BYTES);

	// preamble register
	logic [7:0] preamble_q;

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// frame state
	logic [POS_W-1:0] byte_position_q;
	logic [CRC_W-1:0] crc_q;
	logic [LEN_W-1:0] payload_length_q;
	logic             preamble_matched_q;
	logic [CRC_W-1:0] received_crc_q;

	// output register
	logic      out_valid_q;
	out_item_t out_data_q;

	// next-state values
	logic             advance;
	logic             fire;
	logic             in_range;
	logic [POS_W-1:0] pos_n;
	logic [CRC_W-1:0] crc_n;
	logic [LEN_W-1:0] len_n;
	logic             matched_n;
	logic [CRC_W-1:0] rx_crc_n;
	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] frame_len;
	verdict_t         verdict_n;

	// the pipeline moves unless a result is held under stall
	assign advance  = !(out_valid_q && out_stall);
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		in_range  = byte_position_q < MaxPos;
		matched_n = preamble_matched_q;
		len_n     = payload_length_q;
		crc_n     = crc_q;
		rx_crc_n  = received_crc_q;
		pos_n     = byte_position_q;
		len_ext   = '0;
		if (in_range) begin
			if (byte_position_q == POS_W'(0)) begin
				matched_n = (item_s1.data_byte == preamble_q);
			end else if (byte_position_q == POS_W'(1)) begin
				len_n = {item_s1.data_byte[1:0], payload_length_q[7:0]};
			end else if (byte_position_q == POS_W'(2)) begin
				len_n = {payload_length_q[9:8], item_s1.data_byte};
			end
			len_ext = {1'b0, len_n};
			if (byte_position_q < len_ext + HEADER_BYTES) begin
				crc_n = crc24q_byte(crc_q, item_s1.data_byte);
			end else if (byte_position_q < len_ext + OVERHEAD_BYTES) begin
				rx_crc_n = {received_crc_q[CRC_W-9:0], item_s1.data_byte};
			end
			pos_n = byte_position_q + POS_W'(1);
		end
	end

	// verdict, in priority order
	always_comb begin
		frame_len = {1'b0, len_n} + OVERHEAD_BYTES;
		if (!matched_n) begin
			verdict_n = VERDICT_BAD_PREAMBLE;
		end else if (pos_n < frame_len) begin
			verdict_n = VERDICT_TOO_SHORT;
		end else if (rx_crc_n != crc_n) begin
			verdict_n = VERDICT_CRC_MISMATCH;
		end else begin
			verdict_n = VERDICT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preamble_q <= PREAMBLE_RESET;
		end else if (cfg_we) begin
			preamble_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// frame state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q    <= '0;
			crc_q              <= '0;
			payload_length_q   <= '0;
			preamble_matched_q <= 1'b0;
			received_crc_q     <= '0;
		end else if (fire) begin
			if (item_s1.last_byte) begin
				byte_position_q    <= '0;
				crc_q              <= '0;
				payload_length_q   <= '0;
				preamble_matched_q <= 1'b0;
				received_crc_q     <= '0;
			end else begin
				byte_position_q    <= pos_n;
				crc_q              <= crc_n;
				payload_length_q   <= len_n;
				preamble_matched_q <= matched_n;
				received_crc_q     <= rx_crc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && item_s1.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && item_s1.last_byte) begin
			out_data_q.verdict      <= verdict_n;
			out_data_q.frame_length <= frame_len;
			out_data_q.computed_crc <= crc_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`RFC_ASSERT(a_pos_saturates, clk, arst_n, byte_position_q <= MaxPos)
	`RFC_ASSERT(a_stall_only_when_full, clk, arst_n, !in_stall || valid_s1)
	`RFC_ASSERT_NEXT(a_clear_after_last, clk, arst_n, fire && item_s1.last_byte,
		byte_position_q == '0 && crc_q == '0 && out_valid_q)
	`RFC_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && out_stall,
		out_valid_q && $stable(out_data_q))

endmodule
